// ----- src/sc2hid_pkg.sv -----
`default_nettype none

package sc2hid_pkg;

  // Report geometry.
  localparam int KEY_SLOTS_DEF = 6;
  localparam int OUT_SLOTS     = 6;

  // Command queue between the classifier and the report engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Modifier scan codes.
  localparam logic [15:0] SC_LCTRL  = 16'h001D;
  localparam logic [15:0] SC_LSHIFT = 16'h002A;
  localparam logic [15:0] SC_LALT   = 16'h0038;
  localparam logic [15:0] SC_LGUI   = 16'hE05B;
  localparam logic [15:0] SC_RCTRL  = 16'hE01D;
  localparam logic [15:0] SC_RSHIFT = 16'h0036;
  localparam logic [15:0] SC_RALT   = 16'hE038;
  localparam logic [15:0] SC_RGUI   = 16'hE05C;

  typedef enum logic [1:0] {
    CMD_REJECT = 2'd0,
    CMD_MOD    = 2'd1,
    CMD_KEY    = 2'd2
  } cmd_kind_t;

  // One classified event. The operand is the modifier mask for a
  // modifier command and the HID usage for a key command.
  typedef struct packed {
    cmd_kind_t   kind;
    logic        is_make;
    logic [7:0]  operand;
  } cmd_t;

  typedef struct packed {
    logic [7:0]                  mods;
    logic [OUT_SLOTS-1:0][7:0]   keys;
  } report_t;

  function automatic logic [7:0] modifier_mask(input logic [15:0] code);
    logic [7:0] m;
    case (code)
      SC_LCTRL:  m = 8'h01;
      SC_LSHIFT: m = 8'h02;
      SC_LALT:   m = 8'h04;
      SC_LGUI:   m = 8'h08;
      SC_RCTRL:  m = 8'h10;
      SC_RSHIFT: m = 8'h20;
      SC_RALT:   m = 8'h40;
      SC_RGUI:   m = 8'h80;
      default:   m = 8'h00;
    endcase
    return m;
  endfunction

  // Scan code to HID usage. Where the usage table holds a scan code
  // twice, the lower usage is the one listed. Zero means no usage.
  function automatic logic [7:0] lookup_usage(input logic [15:0] code);
    logic [7:0] u;
    case (code)
      16'h001E: u = 8'h04;  16'h0030: u = 8'h05;  16'h002E: u = 8'h06;
      16'h0020: u = 8'h07;  16'h0012: u = 8'h08;  16'h0021: u = 8'h09;
      16'h0022: u = 8'h0A;  16'h0023: u = 8'h0B;  16'h0017: u = 8'h0C;
      16'h0024: u = 8'h0D;  16'h0025: u = 8'h0E;  16'h0026: u = 8'h0F;
      16'h0032: u = 8'h10;  16'h0031: u = 8'h11;  16'h0018: u = 8'h12;
      16'h0019: u = 8'h13;  16'h0010: u = 8'h14;  16'h0013: u = 8'h15;
      16'h001F: u = 8'h16;  16'h0014: u = 8'h17;  16'h0016: u = 8'h18;
      16'h002F: u = 8'h19;  16'h0011: u = 8'h1A;  16'h002D: u = 8'h1B;
      16'h0015: u = 8'h1C;  16'h002C: u = 8'h1D;  16'h0002: u = 8'h1E;
      16'h0003: u = 8'h1F;  16'h0004: u = 8'h20;  16'h0005: u = 8'h21;
      16'h0006: u = 8'h22;  16'h0007: u = 8'h23;  16'h0008: u = 8'h24;
      16'h0009: u = 8'h25;  16'h000A: u = 8'h26;  16'h000B: u = 8'h27;
      16'h001C: u = 8'h28;  16'h0001: u = 8'h29;  16'h000E: u = 8'h2A;
      16'h000F: u = 8'h2B;  16'h0039: u = 8'h2C;  16'h000C: u = 8'h2D;
      16'h000D: u = 8'h2E;  16'h001A: u = 8'h2F;  16'h001B: u = 8'h30;
      16'h002B: u = 8'h31;  16'h0027: u = 8'h33;  16'h0028: u = 8'h34;
      16'h0029: u = 8'h35;  16'h0033: u = 8'h36;  16'h0034: u = 8'h37;
      16'h0035: u = 8'h38;  16'h003A: u = 8'h39;  16'h003B: u = 8'h3A;
      16'h003C: u = 8'h3B;  16'h003D: u = 8'h3C;  16'h003E: u = 8'h3D;
      16'h003F: u = 8'h3E;  16'h0040: u = 8'h3F;  16'h0041: u = 8'h40;
      16'h0042: u = 8'h41;  16'h0043: u = 8'h42;  16'h0044: u = 8'h43;
      16'h0057: u = 8'h44;  16'h0058: u = 8'h45;  16'hE037: u = 8'h46;
      16'h0046: u = 8'h47;  16'hE046: u = 8'h48;  16'hE052: u = 8'h49;
      16'hE047: u = 8'h4A;  16'hE049: u = 8'h4B;  16'hE053: u = 8'h4C;
      16'hE04F: u = 8'h4D;  16'hE051: u = 8'h4E;  16'hE04D: u = 8'h4F;
      16'h0045: u = 8'h53;  16'hE035: u = 8'h54;  16'h0037: u = 8'h55;
      16'h004A: u = 8'h56;  16'h004E: u = 8'h57;  16'hE01C: u = 8'h58;
      16'h004F: u = 8'h59;  16'h0050: u = 8'h5A;  16'h0051: u = 8'h5B;
      16'h004B: u = 8'h5C;  16'h004C: u = 8'h5D;  16'h004D: u = 8'h5E;
      16'h0047: u = 8'h5F;  16'h0048: u = 8'h60;  16'h0049: u = 8'h61;
      16'h0052: u = 8'h62;  16'h0053: u = 8'h63;  16'h0056: u = 8'h64;
      16'hE05D: u = 8'h65;  16'hE05E: u = 8'h66;  16'h0059: u = 8'h67;
      16'h0064: u = 8'h68;  16'h0065: u = 8'h69;  16'h0066: u = 8'h6A;
      16'h0067: u = 8'h6B;  16'h0068: u = 8'h6C;  16'h0069: u = 8'h6D;
      16'h006A: u = 8'h6E;  16'h006B: u = 8'h6F;  16'h006C: u = 8'h70;
      16'h006D: u = 8'h71;  16'h006E: u = 8'h72;  16'h0076: u = 8'h73;
      16'h007E: u = 8'h85;  16'h0073: u = 8'h87;  16'h0070: u = 8'h88;
      16'h007D: u = 8'h89;  16'h0079: u = 8'h8A;  16'h007B: u = 8'h8B;
      16'h005C: u = 8'h8C;  16'h0072: u = 8'h90;  16'h0071: u = 8'h91;
      16'h0078: u = 8'h92;  16'h0077: u = 8'h93;
      SC_LCTRL:  u = 8'hE0;  SC_LSHIFT: u = 8'hE1;  SC_LALT:   u = 8'hE2;
      SC_LGUI:   u = 8'hE3;  SC_RCTRL:  u = 8'hE4;  SC_RSHIFT: u = 8'hE5;
      SC_RALT:   u = 8'hE6;  SC_RGUI:   u = 8'hE7;
      default:  u = 8'h00;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ----- src/sc2hid_front.sv -----
`default_nettype none

// Classifies one event into a modifier, key or reject command.
module sc2hid_front (
  input  wire logic          mode,
  input  wire logic [15:0]   scan_code,
  input  wire logic          is_make,
  output sc2hid_pkg::cmd_t   cmd
);

  logic [7:0] mask_w;
  logic [7:0] usage_w;

  always_comb begin
    mask_w  = sc2hid_pkg::modifier_mask(scan_code);
    usage_w = sc2hid_pkg::lookup_usage(scan_code);
    cmd.is_make = is_make;
    if (mode) begin
      cmd.operand = usage_w;
      cmd.kind    = (usage_w != 8'h00) ? sc2hid_pkg::CMD_KEY : sc2hid_pkg::CMD_REJECT;
    end else begin
      cmd.operand = mask_w;
      cmd.kind    = (mask_w != 8'h00) ? sc2hid_pkg::CMD_MOD : sc2hid_pkg::CMD_REJECT;
    end
  end

endmodule

`default_nettype wire

// ----- src/sc2hid_queue.sv -----
`default_nettype none

// Small FIFO of classified commands.
module sc2hid_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  input  wire sc2hid_pkg::cmd_t push_cmd,
  output logic               full,
  output logic               head_valid,
  output sc2hid_pkg::cmd_t   head_cmd,
  input  wire logic          pop
);

  sc2hid_pkg::cmd_t                  entries_r [sc2hid_pkg::QUEUE_DEPTH];
  logic [sc2hid_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [sc2hid_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [sc2hid_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                              push;
  logic                              do_pop;

  assign full       = (count_r == sc2hid_pkg::QCNT_W'(sc2hid_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entries_r[rd_ptr_r];
  assign push       = push_valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == sc2hid_pkg::QPTR_W'(sc2hid_pkg::QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == sc2hid_pkg::QPTR_W'(sc2hid_pkg::QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- src/sc2hid_back.sv -----
`default_nettype none

// Applies commands to the held report and owns the result register.
module sc2hid_back #(
  parameter int KEY_SLOTS = sc2hid_pkg::KEY_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire sc2hid_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               res_valid,
  input  wire logic          res_stall,
  output logic               res_accepted,
  output sc2hid_pkg::report_t report
);

  logic [7:0]                  held_mods_r, held_mods_nxt;
  logic [KEY_SLOTS-1:0][7:0]   held_keys_r, held_keys_nxt;
  logic                        valid_r, valid_nxt;
  logic                        acc_r, acc_nxt;
  logic [KEY_SLOTS:0][7:0]     ext_w;
  logic [KEY_SLOTS+sc2hid_pkg::OUT_SLOTS-1:0][7:0] pad_w;

  assign cmd_pop      = cmd_valid && (!valid_r || !res_stall);
  assign res_valid    = valid_r;
  assign res_accepted = acc_r;
  assign ext_w        = {8'h00, held_keys_r};
  assign pad_w        = {{sc2hid_pkg::OUT_SLOTS{8'h00}}, held_keys_r};
  // The report registers only change when a new result is loaded, so
  // they serve as the result payload directly.
  assign report.mods  = held_mods_r;
  assign report.keys  = pad_w[sc2hid_pkg::OUT_SLOTS-1:0];

  always_comb begin
    logic found;
    logic seen_hit;
    logic seen_empty;
    logic any_empty;
    held_mods_nxt = held_mods_r;
    held_keys_nxt = held_keys_r;
    acc_nxt       = acc_r;
    valid_nxt     = valid_r && res_stall;
    found         = 1'b0;
    any_empty     = 1'b0;
    seen_hit      = 1'b0;
    seen_empty    = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      found     = found || (held_keys_r[i] == cmd.operand);
      any_empty = any_empty || (held_keys_r[i] == 8'h00);
    end
    if (cmd_pop) begin
      valid_nxt = 1'b1;
      case (cmd.kind)
        sc2hid_pkg::CMD_MOD: begin
          acc_nxt = 1'b1;
          if (cmd.is_make) begin
            held_mods_nxt = held_mods_r | cmd.operand;
          end else begin
            held_mods_nxt = held_mods_r & ~cmd.operand;
          end
        end
        sc2hid_pkg::CMD_KEY: begin
          if (cmd.is_make) begin
            acc_nxt = found || any_empty;
            if (!found) begin
              // Fill the first empty slot.
              for (int i = 0; i < KEY_SLOTS; i++) begin
                if (!seen_empty && held_keys_r[i] == 8'h00) begin
                  held_keys_nxt[i] = cmd.operand;
                end
                seen_empty = seen_empty || (held_keys_r[i] == 8'h00);
              end
            end
          end else begin
            acc_nxt = found;
            // From the matching slot on, every slot takes its successor.
            for (int i = 0; i < KEY_SLOTS; i++) begin
              seen_hit = seen_hit || (held_keys_r[i] == cmd.operand);
              if (seen_hit) begin
                held_keys_nxt[i] = ext_w[i+1];
              end
            end
          end
        end
        default: begin
          acc_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_mods_r <= '0;
      held_keys_r <= '0;
      valid_r     <= 1'b0;
      acc_r       <= 1'b0;
    end else begin
      held_mods_r <= held_mods_nxt;
      held_keys_r <= held_keys_nxt;
      valid_r     <= valid_nxt;
      acc_r       <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/scan_code_to_hid_key_report_unit.sv -----
`default_nettype none

// Keeps a USB HID boot keyboard report (modifier byte plus key slots)
// from a stream of PS/2 set-1 make and break beats. Each input beat gives
// exactly one result beat carrying an accepted flag and the whole report
// as it stands after that event; a rejected event still returns the
// unchanged report. An accepted beat lands in a two-entry command
// queue; the report engine pops it while the result register is free or
// being drained and registers the result, shown as out_valid. It applies
// one command per cycle, which sets the sustained rate at one beat per cycle
// while the result side is not stalled. Slots beyond KEY_SLOTS read as
// zero; with more than six slots only the first six are reported.
module scan_code_to_hid_key_report_unit #(
  parameter int KEY_SLOTS = sc2hid_pkg::KEY_SLOTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic         in_mode,
  input  wire logic [15:0]  in_scan_code,
  input  wire logic         in_is_make,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic              out_accepted,
  output logic [7:0]        out_modifier_bits,
  output logic [7:0]        out_key_slot0,
  output logic [7:0]        out_key_slot1,
  output logic [7:0]        out_key_slot2,
  output logic [7:0]        out_key_slot3,
  output logic [7:0]        out_key_slot4,
  output logic [7:0]        out_key_slot5
);

  sc2hid_pkg::cmd_t     front_cmd;
  sc2hid_pkg::cmd_t     head_cmd;
  sc2hid_pkg::report_t  report;
  logic                 q_full;
  logic                 head_valid;
  logic                 head_pop;

  // The front only classifies; the input stalls while the queue is full.
  sc2hid_front u_front (
    .mode      (in_mode),
    .scan_code (in_scan_code),
    .is_make   (in_is_make),
    .cmd       (front_cmd)
  );

  assign in_stall = q_full;

  sc2hid_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (head_pop)
  );

  // The back holds the report and the result register, and takes the
  // next command whenever the result register is free or being drained.
  sc2hid_back #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (head_valid),
    .cmd          (head_cmd),
    .cmd_pop      (head_pop),
    .res_valid    (out_valid),
    .res_stall    (out_stall),
    .res_accepted (out_accepted),
    .report       (report)
  );

  assign out_modifier_bits = report.mods;
  assign out_key_slot0     = report.keys[0];
  assign out_key_slot1     = report.keys[1];
  assign out_key_slot2     = report.keys[2];
  assign out_key_slot3     = report.keys[3];
  assign out_key_slot4     = report.keys[4];
  assign out_key_slot5     = report.keys[5];

endmodule

`default_nettype wire

// ----- tb/sv/tb_scan_code_to_hid_key_report_unit.sv -----
`timescale 1ns / 1ps

module tb_scan_code_to_hid_key_report_unit;

  // Event encodings on the input beat.
  localparam logic MODE_MOD = 1'b0;
  localparam logic MODE_KEY = 1'b1;
  localparam logic BREAK    = 1'b0;
  localparam logic MAKE     = 1'b1;

  // Directed rows either carry a typed-in expectation or defer to the
  // keyboard model below.
  localparam logic PREDICT  = 1'b0;
  localparam logic TYPED    = 1'b1;
  localparam logic REJECTED = 1'b0;
  localparam logic TAKEN    = 1'b1;

  // Ordinary HID usages 0x00..0x97 and the scan code each one answers to.
  // Entries holding zero are unused. A scan code listed twice resolves to
  // the lower usage, because the search below runs upward.
  localparam int PLAIN_USAGES = 152;
  localparam logic [15:0] SCAN_BY_USAGE [0:PLAIN_USAGES-1] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h001E, 16'h0030, 16'h002E, 16'h0020,
    16'h0012, 16'h0021, 16'h0022, 16'h0023, 16'h0017, 16'h0024, 16'h0025, 16'h0026,
    16'h0032, 16'h0031, 16'h0018, 16'h0019, 16'h0010, 16'h0013, 16'h001F, 16'h0014,
    16'h0016, 16'h002F, 16'h0011, 16'h002D, 16'h0015, 16'h002C, 16'h0002, 16'h0003,
    16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009, 16'h000A, 16'h000B,
    16'h001C, 16'h0001, 16'h000E, 16'h000F, 16'h0039, 16'h000C, 16'h000D, 16'h001A,
    16'h001B, 16'h002B, 16'h002B, 16'h0027, 16'h0028, 16'h0029, 16'h0033, 16'h0034,
    16'h0035, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F, 16'h0040,
    16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0057, 16'h0058, 16'hE037, 16'h0046,
    16'hE046, 16'hE052, 16'hE047, 16'hE049, 16'hE053, 16'hE04F, 16'hE051, 16'hE04D,
    16'h0000, 16'h0000, 16'h0000, 16'h0045, 16'hE035, 16'h0037, 16'h004A, 16'h004E,
    16'hE01C, 16'h004F, 16'h0050, 16'h0051, 16'h004B, 16'h004C, 16'h004D, 16'h0047,
    16'h0048, 16'h0049, 16'h0052, 16'h0053, 16'h0056, 16'hE05D, 16'hE05E, 16'h0059,
    16'h0064, 16'h0065, 16'h0066, 16'h0067, 16'h0068, 16'h0069, 16'h006A, 16'h006B,
    16'h006C, 16'h006D, 16'h006E, 16'h0076, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h007E, 16'h0000, 16'h0073,
    16'h0070, 16'h007D, 16'h0079, 16'h007B, 16'h005C, 16'h0000, 16'h0000, 16'h0000,
    16'h0072, 16'h0071, 16'h0078, 16'h0077, 16'h0076, 16'h0000, 16'h0000, 16'h0000
  };

  // The eight modifier keys in modifier-byte order. Entry b is bit b of the
  // modifier byte and, as an ordinary key, HID usage 0xE0 + b.
  localparam logic [7:0] MOD_USAGE_BASE = 8'hE0;
  localparam logic [15:0] MOD_CODES [0:7] = '{
    sc2hid_pkg::SC_LCTRL, sc2hid_pkg::SC_LSHIFT, sc2hid_pkg::SC_LALT,
    sc2hid_pkg::SC_LGUI,  sc2hid_pkg::SC_RCTRL,  sc2hid_pkg::SC_RSHIFT,
    sc2hid_pkg::SC_RALT,  sc2hid_pkg::SC_RGUI
  };

  // One report beat as the result channel carries it.
  typedef struct packed {
    logic                                  accepted;
    logic [7:0]                            mods;
    logic [sc2hid_pkg::OUT_SLOTS-1:0][7:0] keys;
  } hid_report_t;

  // One row of the directed table. Typed rows expect an empty key report.
  typedef struct packed {
    logic        mode;
    logic [15:0] code;
    logic        make;
    logic        typed;
    logic        acc;
    logic [7:0]  mods;
  } stim_row_t;

  // Directed opening: bad codes and extreme field values against a fresh
  // report, every modifier but left alt with right control on its own bit,
  // the scan codes listed twice in the usage table, a modifier sent as an
  // ordinary key, a press of a held key, a press into a full report, releases
  // of a key not held, and releases from the middle, first and last slot.
  localparam int DIRECTED_ROWS = 25;
  localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    '{MODE_KEY, 16'h0000,              MAKE,  TYPED,   REJECTED, 8'h00},
    '{MODE_KEY, 16'hFFFF,              MAKE,  TYPED,   REJECTED, 8'h00},
    '{MODE_MOD, 16'h0000,              MAKE,  TYPED,   REJECTED, 8'h00},
    '{MODE_MOD, 16'hFFFF,              BREAK, TYPED,   REJECTED, 8'h00},
    '{MODE_KEY, 16'h001E,              BREAK, TYPED,   REJECTED, 8'h00},
    '{MODE_MOD, sc2hid_pkg::SC_LCTRL,  MAKE,  TYPED,   TAKEN,    8'h01},
    '{MODE_MOD, sc2hid_pkg::SC_RCTRL,  MAKE,  TYPED,   TAKEN,    8'h11},
    '{MODE_MOD, sc2hid_pkg::SC_RGUI,   MAKE,  TYPED,   TAKEN,    8'h91},
    '{MODE_MOD, sc2hid_pkg::SC_LCTRL,  BREAK, TYPED,   TAKEN,    8'h90},
    '{MODE_MOD, sc2hid_pkg::SC_LSHIFT, MAKE,  PREDICT, REJECTED, 8'h00},
    '{MODE_MOD, sc2hid_pkg::SC_LGUI,   MAKE,  PREDICT, REJECTED, 8'h00},
    '{MODE_MOD, sc2hid_pkg::SC_RSHIFT, MAKE,  PREDICT, REJECTED, 8'h00},
    '{MODE_MOD, sc2hid_pkg::SC_RALT,   MAKE,  PREDICT, REJECTED, 8'h00},
    '{MODE_KEY, 16'h001E,              MAKE,  PREDICT, REJECTED, 8'h00},
    '{MODE_KEY, 16'h002B,              MAKE,  PREDICT, REJECTED, 8'h00},
    '{MODE_KEY, 16'h0076,              MAKE,  PREDICT, REJECTED, 8'h00},
    '{MODE_KEY, 16'h001E,              MAKE,  PREDICT, REJECTED, 8'h00},
    '{MODE_KEY, sc2hid_pkg::SC_LALT,   MAKE,  PREDICT, REJECTED, 8'h00},
    '{MODE_KEY, 16'h0077,              MAKE,  PREDICT, REJECTED, 8'h00},
    '{MODE_KEY, 16'hE05E,              MAKE,  PREDICT, REJECTED, 8'h00},
    '{MODE_KEY, 16'h002E,              MAKE,  PREDICT, REJECTED, 8'h00},
    '{MODE_KEY, 16'h002E,              BREAK, PREDICT, REJECTED, 8'h00},
    '{MODE_KEY, 16'h002B,              BREAK, PREDICT, REJECTED, 8'h00},
    '{MODE_KEY, 16'h001E,              BREAK, PREDICT, REJECTED, 8'h00},
    '{MODE_KEY, 16'hE05E,              BREAK, PREDICT, REJECTED, 8'h00}
  };

  localparam int RANDOM_PER_PHASE = 270;
  localparam int MAX_GAP          = 20;
  localparam int REPORT_LIMIT     = 10;

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_mode           = 1'b0;
  logic [15:0] in_scan_code      = 16'h0000;
  logic        in_is_make        = 1'b0;
  logic        out_stall         = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_accepted;
  logic [7:0]  out_modifier_bits;
  logic [7:0]  out_key_slot0;
  logic [7:0]  out_key_slot1;
  logic [7:0]  out_key_slot2;
  logic [7:0]  out_key_slot3;
  logic [7:0]  out_key_slot4;
  logic [7:0]  out_key_slot5;

  // Keyboard model state: what the block should be holding right now,
  // advanced once per input beat at the edge that accepts it.
  logic [7:0] kbd_mods;
  logic [7:0] kbd_keys [sc2hid_pkg::OUT_SLOTS];

  // Reports still owed by the block, oldest first.
  hid_report_t pending_reports [$];

  // Traffic shaping, in percent per cycle.
  int idle_pct  = 0;
  int stall_pct = 0;

  int mismatches    = 0;
  int beats_checked = 0;
  int taken_seen    = 0;
  int full_refusals = 0;

  scan_code_to_hid_key_report_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_scan_code      (in_scan_code),
    .in_is_make        (in_is_make),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accepted      (out_accepted),
    .out_modifier_bits (out_modifier_bits),
    .out_key_slot0     (out_key_slot0),
    .out_key_slot1     (out_key_slot1),
    .out_key_slot2     (out_key_slot2),
    .out_key_slot3     (out_key_slot3),
    .out_key_slot4     (out_key_slot4),
    .out_key_slot5     (out_key_slot5)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A generous ceiling on the run time, well beyond what the slowest phases need.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Modifier-byte bit for a scan code, or zero if it names no modifier.
  function automatic logic [7:0] mod_mask_of(input logic [15:0] code);
    for (int b = 0; b < 8; b++) begin
      if (MOD_CODES[b] == code) return 8'h01 << b;
    end
    return 8'h00;
  endfunction

  // Lowest HID usage whose scan code matches. Usage zero stands for "no
  // key", which is also what the unused low entries resolve to.
  function automatic logic [7:0] usage_of_scan(input logic [15:0] code);
    for (int u = 0; u < PLAIN_USAGES; u++) begin
      if (SCAN_BY_USAGE[u] == code) return 8'(u);
    end
    for (int b = 0; b < 8; b++) begin
      if (MOD_CODES[b] == code) return MOD_USAGE_BASE + 8'(b);
    end
    return 8'h00;
  endfunction

  function automatic logic [15:0] scan_of_usage(input logic [7:0] usage);
    if (usage >= MOD_USAGE_BASE && usage < MOD_USAGE_BASE + 8'd8) begin
      return MOD_CODES[usage - MOD_USAGE_BASE];
    end
    if (usage < PLAIN_USAGES) return SCAN_BY_USAGE[usage];
    return 16'h0000;
  endfunction

  // Applies one event to the keyboard model and returns the report the
  // block must answer with. Held keys always pack into the lowest slots.
  function automatic hid_report_t apply_key_event(input logic mode, input logic [15:0] code,
                                                  input logic make);
    hid_report_t rpt;
    logic [7:0]  mask;
    logic [7:0]  usage;
    logic        ok;
    int          hit;
    ok = 1'b0;
    if (mode == MODE_MOD) begin
      mask = mod_mask_of(code);
      ok   = (mask != 8'h00);
      if (ok) kbd_mods = make ? (kbd_mods | mask) : (kbd_mods & ~mask);
    end else begin
      usage = usage_of_scan(code);
      hit   = -1;
      for (int j = 0; j < sc2hid_pkg::OUT_SLOTS; j++) begin
        if (hit < 0 && kbd_keys[j] == usage) hit = j;
      end
      if (usage == 8'h00) begin
        ok = 1'b0;
      end else if (make) begin
        if (hit >= 0) begin
          ok = 1'b1;
        end else begin
          for (int j = 0; j < sc2hid_pkg::OUT_SLOTS; j++) begin
            if (!ok && kbd_keys[j] == 8'h00) begin
              kbd_keys[j] = usage;
              ok          = 1'b1;
            end
          end
          if (!ok) full_refusals++;
        end
      end else if (hit >= 0) begin
        // Close the gap: later keys move down one slot, the last empties.
        for (int j = hit; j < sc2hid_pkg::OUT_SLOTS - 1; j++) kbd_keys[j] = kbd_keys[j + 1];
        kbd_keys[sc2hid_pkg::OUT_SLOTS-1] = 8'h00;
        ok = 1'b1;
      end
    end
    rpt.accepted = ok;
    rpt.mods     = kbd_mods;
    for (int j = 0; j < sc2hid_pkg::OUT_SLOTS; j++) rpt.keys[j] = kbd_keys[j];
    return rpt;
  endfunction

  // A scan code that maps to some real key, ordinary or modifier.
  function automatic logic [15:0] random_key_code();
    int idx;
    forever begin
      idx = $urandom_range(0, PLAIN_USAGES + 7);
      if (idx >= PLAIN_USAGES) return MOD_CODES[idx - PLAIN_USAGES];
      if (SCAN_BY_USAGE[idx] != 16'h0000) return SCAN_BY_USAGE[idx];
    end
  endfunction

  // Random traffic is mostly typing: presses of real keys and releases of
  // keys that are actually down, so the report fills, overflows and drains.
  // A share of modifier beats and of raw noise is mixed in.
  function automatic stim_row_t random_event();
    stim_row_t row;
    int        roll;
    int        held;
    roll = $urandom_range(0, 99);
    held = 0;
    for (int j = 0; j < sc2hid_pkg::OUT_SLOTS; j++) begin
      if (kbd_keys[j] != 8'h00) held++;
    end
    row       = '0;
    row.typed = PREDICT;
    row.mode  = MODE_KEY;
    row.make  = 1'($urandom_range(0, 1));
    row.code  = 16'($urandom);
    if (roll < 12) begin
      row.mode = 1'($urandom_range(0, 1));
    end else if (roll < 35) begin
      row.mode = MODE_MOD;
      row.code = MOD_CODES[$urandom_range(0, 7)];
    end else begin
      row.make = ($urandom_range(0, 99) <
                  ((held >= sc2hid_pkg::OUT_SLOTS - 1) ? 45 : 65));
      if (held > 0 && $urandom_range(0, 9) < (row.make ? 2 : 8)) begin
        row.code = scan_of_usage(kbd_keys[$urandom_range(0, held - 1)]);
      end else begin
        row.code = random_key_code();
      end
    end
    return row;
  endfunction

  // Drives one input beat and waits for the edge that takes it. The task is
  // entered and left right after a rising edge, so each of its nonblocking
  // writes lands in a time step of its own.
  task automatic post_event(input stim_row_t row);
    hid_report_t predicted;
    hid_report_t typed_rpt;
    int          gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= row.mode;
    in_scan_code <= row.code;
    in_is_make   <= row.make;
    do @(posedge clk); while (in_stall);
    predicted = apply_key_event(row.mode, row.code, row.make);
    if (row.typed == TYPED) begin
      typed_rpt          = '0;
      typed_rpt.accepted = row.acc;
      typed_rpt.mods     = row.mods;
      pending_reports.push_back(typed_rpt);
    end else begin
      pending_reports.push_back(predicted);
    end
  endtask

  // Stops sending and lets the block hand back everything it owes.
  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // Result side: random stall per cycle, and a check of every beat taken.
  // Everything is sampled at the edge, before any of this step's updates.
  always @(posedge clk) begin : report_check
    hid_report_t want;
    hid_report_t got;
    logic        bad;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.accepted = out_accepted;
        got.mods     = out_modifier_bits;
        got.keys     = {out_key_slot5, out_key_slot4, out_key_slot3,
                        out_key_slot2, out_key_slot1, out_key_slot0};
        beats_checked++;
        if (out_accepted === 1'b1) taken_seen++;
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: unexpected report beat acc %b mods %h keys %h",
                     $realtime, got.accepted, got.mods, got.keys);
          end
        end else begin
          want = pending_reports.pop_front();
          bad  = (got.accepted !== want.accepted) || (got.mods !== want.mods);
          for (int j = 0; j < sc2hid_pkg::OUT_SLOTS; j++) begin
            if (got.keys[j] !== want.keys[j]) bad = 1'b1;
          end
          if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: mismatch: want acc %b mods %h keys %h, got acc %b mods %h keys %h",
                       $realtime, want.accepted, want.mods, want.keys,
                       got.accepted, got.mods, got.keys);
            end
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    int sender_pct [4];
    int receiver_pct [4];
    sender_pct   = '{0, 74, 0, 24};
    receiver_pct = '{0, 0, 74, 24};
    kbd_mods = 8'h00;
    for (int j = 0; j < sc2hid_pkg::OUT_SLOTS; j++) kbd_keys[j] = 8'h00;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Phases: free running, a sparse sender, a slow receiver, then both.
    // The directed rows run free; each phase ends with a full drain so the
    // sender also sits idle while the block empties out.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = sender_pct[phase];
      stall_pct <= receiver_pct[phase];
      if (phase == 0) begin
        for (int i = 0; i < DIRECTED_ROWS; i++) post_event(DIRECTED[i]);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) post_event(random_event());
      drain_reports();
    end

    // Idle on in case anything stray is still on its way out.
    repeat (8) @(posedge clk);
    $display("Checked %0d report beats over four traffic phases: %0d events taken,",
             beats_checked, taken_seen);
    $display("%0d presses refused by a full report, %0d mismatching beats.",
             full_refusals, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
